FILE: design/ssra_pkg.sv
// Shared types and constants for the spill scaler rate accumulator.
package ssra_pkg;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned NumScalers = 8;

  typedef logic [FieldWidth-1:0] field_t;

  typedef struct packed {
    field_t spill_start_count;
    field_t spill_stop_count;
    field_t accepted_trig_scaler;
    field_t free_trig_scaler;
    field_t beam_monitor_new_scaler;
    field_t beam_monitor_old_scaler;
    field_t ion_chamber_scaler;
    field_t scint_a_scaler;
    field_t scint_b_scaler;
    field_t scint_c_scaler;
  } in_req_t;

  typedef struct packed {
    field_t accepted_total;
    field_t free_total;
    field_t monitor_new_total;
    field_t ion_chamber_total;
    field_t monitor_old_total;
    field_t scint_a_total;
    field_t scint_b_total;
    field_t scint_c_total;
    field_t spill_number;
  } out_req_t;

  typedef logic [NumScalers-1:0][FieldWidth-1:0] slots_t;

  // Tracker verdict on the item held in the input register.
  typedef struct packed {
    logic     close;
    out_req_t data;
  } trk_res_t;

  // Gather the scalers in total-slot order.
  function automatic slots_t to_slots(in_req_t req);
    slots_t s;
    s[0] = req.accepted_trig_scaler;
    s[1] = req.free_trig_scaler;
    s[2] = req.beam_monitor_new_scaler;
    s[3] = req.ion_chamber_scaler;
    s[4] = req.beam_monitor_old_scaler;
    s[5] = req.scint_a_scaler;
    s[6] = req.scint_b_scaler;
    s[7] = req.scint_c_scaler;
    return s;
  endfunction

endpackage

FILE: design/ssra_tracker.sv
// Spill state tracker: reference latches, per-spill totals and spill counter.
module ssra_tracker import ssra_pkg::*; #(
  parameter int unsigned ScalerWidth = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_req_t  item_i,
  output trk_res_t res_o
);

  logic                                     first_q;
  field_t                                   last_start_q;
  field_t                                   last_stop_q;
  logic [NumScalers-1:0][ScalerWidth-1:0]   prev_q;
  logic [NumScalers-1:0][ScalerWidth-1:0]   tot_q;
  field_t                                   spill_q;

  slots_t                                   slots;
  logic [NumScalers-1:0][ScalerWidth-1:0]   val;
  logic [NumScalers-1:0][ScalerWidth-1:0]   delta;
  logic [NumScalers-1:0][ScalerWidth-1:0]   sum;
  logic [NumScalers-1:0][FieldWidth-1:0]    tot_out;
  logic                                     same;
  logic                                     grow;
  logic                                     close;

  assign slots = to_slots(item_i);
  assign same  = (item_i.spill_start_count == last_start_q) &&
                 (item_i.spill_stop_count == last_stop_q);
  assign grow  = (item_i.spill_start_count > last_start_q) &&
                 (item_i.spill_stop_count == last_stop_q);
  assign close = !first_q && !same && !grow;

  for (genvar g = 0; g < NumScalers; g++) begin : g_lane
    if (ScalerWidth > FieldWidth) begin : g_wide
      assign val[g]     = {{(ScalerWidth-FieldWidth){1'b0}}, slots[g]};
      assign tot_out[g] = tot_q[g][FieldWidth-1:0];
    end else if (ScalerWidth == FieldWidth) begin : g_same
      assign val[g]     = slots[g];
      assign tot_out[g] = tot_q[g];
    end else begin : g_narrow
      assign val[g]     = slots[g][ScalerWidth-1:0];
      assign tot_out[g] = {{(FieldWidth-ScalerWidth){1'b0}}, tot_q[g]};
    end
    assign delta[g] = val[g] - prev_q[g];
    assign sum[g]   = tot_q[g] + delta[g];
  end

  assign res_o.close                  = close;
  assign res_o.data.accepted_total    = tot_out[0];
  assign res_o.data.free_total        = tot_out[1];
  assign res_o.data.monitor_new_total = tot_out[2];
  assign res_o.data.ion_chamber_total = tot_out[3];
  assign res_o.data.monitor_old_total = tot_out[4];
  assign res_o.data.scint_a_total     = tot_out[5];
  assign res_o.data.scint_b_total     = tot_out[6];
  assign res_o.data.scint_c_total     = tot_out[7];
  assign res_o.data.spill_number      = spill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 1'b1;
      last_start_q <= '0;
      last_stop_q  <= '0;
      prev_q       <= '0;
      tot_q        <= '0;
      spill_q      <= '0;
    end else if (step_i) begin
      if (first_q) begin
        // Latch references only.
        first_q      <= 1'b0;
        prev_q       <= val;
        tot_q        <= '0;
        last_start_q <= item_i.spill_start_count;
        last_stop_q  <= item_i.spill_stop_count;
      end else if (grow) begin
        prev_q <= val;
        tot_q  <= sum;
      end else if (close) begin
        // Restart totals from this readout's deltas.
        prev_q       <= val;
        tot_q        <= delta;
        spill_q      <= spill_q + 1'b1;
        last_start_q <= item_i.spill_start_count;
        last_stop_q  <= item_i.spill_stop_count;
      end
    end
  end

`ifndef ASSERT_OFF
  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && first_q |=> !first_q)
    else $error("reference latch not taken on first readout");

  a_no_close_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> !close)
    else $error("spill closed before references were latched");

  a_spill_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && close |=> spill_q == $past(spill_q) + 1'b1)
    else $error("spill number did not advance on close");
`endif

endmodule

FILE: design/spill_scaler_rate_accumulator.sv
// Top level of the spill scaler rate accumulator.
//
// One scaler readout is taken per clock unless stalled; each is registered,
// then judged against the latched spill-start and spill-stop references in a
// single pass of eight independent subtract-and-add lanes; a readout that
// closes a spill yields one result request carrying the eight totals and
// the spill number, which is registered into the output stage. Results
// queue in a two-entry output stage (output register plus skid register),
// so readouts keep flowing while results wait. The input side stalls only
// when both output entries are occupied and the registered readout would
// close another spill. Totals are kept SCALER_WIDTH bits wide and reported
// in their low 32 bits; scaler inputs are truncated or zero-extended to
// that width first. The very first readout after reset only sets the
// references and produces nothing.
module spill_scaler_rate_accumulator import ssra_pkg::*; #(
  parameter int unsigned SCALER_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  // Input register.
  logic     item_valid_q;
  logic     item_valid_d;
  in_req_t  item_q;

  // Output register and skid register.
  logic     out_valid_q;
  logic     out_valid_d;
  out_req_t out_q;
  out_req_t out_d;
  logic     skid_valid_q;
  logic     skid_valid_d;
  out_req_t skid_q;
  out_req_t skid_d;

  trk_res_t res;
  logic     accept;
  logic     advance;
  logic     push;
  logic     pop;

  ssra_tracker #(
    .ScalerWidth(SCALER_WIDTH)
  ) u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .res_o  (res)
  );

  // The held readout moves on unless it needs an output slot and none is free.
  assign advance    = item_valid_q && (!res.close || !skid_valid_q);
  assign in_stall_o = item_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = advance && res.close;
  assign pop        = out_valid_q && !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
  end

  // Queue results: fill the output register first, spill into the skid.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        out_d = res.data;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_d       = res.data;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = res.data;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers: hold unless loaded.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_req_i;
    end
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && skid_valid_q))
    else $error("result pushed into a full output stage");

  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid_q && res.close && skid_valid_q)
    else $error("input stalled without a blocked closing readout");
`endif

endmodule

FILE: verif/spill_total_checker.sv
// Checker: predicts the per-spill totals from accepted readouts and compares each result.
module spill_total_checker import ssra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  in_req_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  out_req_t out_req_i,
  output int       mismatch_count_o,
  output int       pending_o,
  output int       closed_count_o,
  output int       grown_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumTotalFields = 9;
  localparam int ReportLimit = 10;

  typedef field_t slot_arr_t [NumScalers];
  typedef logic [NumTotalFields-1:0][FieldWidth-1:0] total_words_t;

  typedef enum logic [1:0] {
    READ_LATCH,
    READ_IDLE,
    READ_GROW,
    READ_CLOSE
  } verdict_e;

  logic      awaiting_first_q;
  field_t    ref_start_q;
  field_t    ref_stop_q;
  field_t    spill_index_q;
  slot_arr_t last_reading_q;
  slot_arr_t spill_sum_q;
  out_req_t  due_totals_q [$];
  int        mismatches;
  int        closed_seen;
  int        grown_seen;

  function automatic slot_arr_t gather_scalers(in_req_t r);
    slot_arr_t s;
    s[0] = r.accepted_trig_scaler;
    s[1] = r.free_trig_scaler;
    s[2] = r.beam_monitor_new_scaler;
    s[3] = r.ion_chamber_scaler;
    s[4] = r.beam_monitor_old_scaler;
    s[5] = r.scint_a_scaler;
    s[6] = r.scint_b_scaler;
    s[7] = r.scint_c_scaler;
    return s;
  endfunction

  function automatic string total_label(int k);
    case (k)
      0:       return "accepted_total";
      1:       return "free_total";
      2:       return "monitor_new_total";
      3:       return "ion_chamber_total";
      4:       return "monitor_old_total";
      5:       return "scint_a_total";
      6:       return "scint_b_total";
      7:       return "scint_c_total";
      default: return "spill_number";
    endcase
  endfunction

  // Judge one readout against the latched start and stop; fill the totals when it closes.
  function automatic verdict_e judge_readout(input in_req_t r, output out_req_t closed);
    slot_arr_t now_val;
    logic      restart;
    now_val = gather_scalers(r);
    closed = '0;
    if (awaiting_first_q) begin
      awaiting_first_q = 1'b0;
      ref_start_q = r.spill_start_count;
      ref_stop_q = r.spill_stop_count;
      foreach (now_val[k]) begin
        last_reading_q[k] = now_val[k];
        spill_sum_q[k] = '0;
      end
      return READ_LATCH;
    end
    if (r.spill_start_count == ref_start_q && r.spill_stop_count == ref_stop_q) begin
      return READ_IDLE;
    end
    // Growth is judged against the start latched at the last close, not the last readout.
    restart = !(r.spill_start_count > ref_start_q && r.spill_stop_count == ref_stop_q);
    if (restart) begin
      closed.accepted_total = spill_sum_q[0];
      closed.free_total = spill_sum_q[1];
      closed.monitor_new_total = spill_sum_q[2];
      closed.ion_chamber_total = spill_sum_q[3];
      closed.monitor_old_total = spill_sum_q[4];
      closed.scint_a_total = spill_sum_q[5];
      closed.scint_b_total = spill_sum_q[6];
      closed.scint_c_total = spill_sum_q[7];
      closed.spill_number = spill_index_q;
      spill_index_q = spill_index_q + 1'b1;
      ref_start_q = r.spill_start_count;
      ref_stop_q = r.spill_stop_count;
    end
    foreach (now_val[k]) begin
      spill_sum_q[k] = (restart ? field_t'(0) : spill_sum_q[k]) + (now_val[k] - last_reading_q[k]);
      last_reading_q[k] = now_val[k];
    end
    return restart ? READ_CLOSE : READ_GROW;
  endfunction

  task automatic compare_totals(input out_req_t want, input out_req_t got);
    total_words_t w;
    total_words_t g;
    int           k;
    w = want;
    g = got;
    for (k = 0; k < NumTotalFields; k++) begin
      if (g[NumTotalFields-1-k] !== w[NumTotalFields-1-k]) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: spill %0d %s expected %h, got %h", $realtime, want.spill_number,
                   total_label(k), w[NumTotalFields-1-k], g[NumTotalFields-1-k]);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t closed;
    verdict_e verdict;
    if (!rst_ni) begin
      awaiting_first_q = 1'b1;
      ref_start_q = '0;
      ref_stop_q = '0;
      spill_index_q = '0;
      foreach (spill_sum_q[k]) begin
        spill_sum_q[k] = '0;
        last_reading_q[k] = '0;
      end
      due_totals_q.delete();
      mismatches = 0;
      closed_seen = 0;
      grown_seen = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        closed_seen++;
        if (due_totals_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: spill result with none due, spill_number %h", $realtime,
                     out_req_i.spill_number);
          end
        end else begin
          compare_totals(due_totals_q.pop_front(), out_req_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        verdict = judge_readout(in_req_i, closed);
        if (verdict == READ_CLOSE) due_totals_q.push_back(closed);
        if (verdict == READ_GROW) grown_seen++;
      end
    end
    mismatch_count_o <= mismatches;
    pending_o <= due_totals_q.size();
    closed_count_o <= closed_seen;
    grown_count_o <= grown_seen;
  end

endmodule

FILE: verif/tb_spill_scaler_rate_accumulator.sv
// Testbench top: drives scaler readouts into the accumulator and gives the verdict.
module tb_spill_scaler_rate_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  import ssra_pkg::*;

  localparam int ReadoutTarget = 2000;
  localparam int IdleLimit = 2000;   // cycles with no request moving on either side
  localparam int SettleCycles = 8;   // register stage plus the two-entry output stage

  // Receiver stall styles, switched at random.
  typedef enum logic [1:0] {
    RECV_FREE,
    RECV_COIN,
    RECV_RUNS,
    RECV_PATTERN
  } recv_mode_e;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  int mismatch_count;
  int pending_results;
  int closed_count;
  int grown_count;

  // Sender bookkeeping: what the block should have latched, so that growth is steered.
  logic   mirror_fresh = 1'b1;
  field_t mirror_start = '0;
  field_t mirror_stop = '0;
  // Scaler readings in request order: accepted, free, monitor new, monitor old,
  // ion chamber, scintillators a, b, c.
  field_t scal [NumScalers];
  int     readouts_sent = 0;
  int     burst_left = 0;
  int     idle_cycles = 0;

  spill_scaler_rate_accumulator u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_req_i,
    .out_valid_o,
    .out_stall_i,
    .out_req_o
  );

  spill_total_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i       (in_stall_o),
    .in_req_i,
    .out_valid_i      (out_valid_o),
    .out_stall_i,
    .out_req_i        (out_req_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results),
    .closed_count_o   (closed_count),
    .grown_count_o    (grown_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: %0d cycles without a request moving", IdleLimit);
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver back-pressure: free, coin-flip, long runs, or a repeating 8-bit mask.
  recv_mode_e  recv_mode = RECV_FREE;
  int          recv_left = 0;
  int          run_left = 0;
  logic        run_stalled = 1'b0;
  logic [7:0]  stall_mask = '0;
  int unsigned pattern_cycle = 0;

  always @(negedge clk_i) begin
    logic next_stall;
    if (recv_left == 0) begin
      recv_mode = recv_mode_e'($urandom_range(0, 3));
      recv_left = $urandom_range(32, 400);
      stall_mask = 8'($urandom());
    end
    recv_left--;
    pattern_cycle++;
    case (recv_mode)
      RECV_FREE: next_stall = 1'b0;
      RECV_COIN: next_stall = 1'($urandom_range(0, 1));
      RECV_RUNS: begin
        if (run_left == 0) begin
          run_stalled = !run_stalled;
          run_left = $urandom_range(1, 20);
        end
        run_left--;
        next_stall = run_stalled;
      end
      default: next_stall = stall_mask[pattern_cycle % 8];
    endcase
    out_stall_i <= next_stall;
  end

  // Offer one readout and hold it until it is taken; valid stays high for the next one.
  task automatic send_readout(input field_t start, input field_t stop);
    in_req_t r;
    r.spill_start_count = start;
    r.spill_stop_count = stop;
    r.accepted_trig_scaler = scal[0];
    r.free_trig_scaler = scal[1];
    r.beam_monitor_new_scaler = scal[2];
    r.beam_monitor_old_scaler = scal[3];
    r.ion_chamber_scaler = scal[4];
    r.scint_a_scaler = scal[5];
    r.scint_b_scaler = scal[6];
    r.scint_c_scaler = scal[7];
    // A stop change or a falling start closes the spill and relatches both counters.
    if (mirror_fresh || stop != mirror_stop || start < mirror_start) begin
      mirror_start = start;
      mirror_stop = stop;
    end
    mirror_fresh = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    readouts_sent++;
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Hold the sender until every spill result due has come out.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // Bursts of random length with gaps; every 500 readouts a stretch runs back to back.
  task automatic pace_sender();
    if ((readouts_sent % 500) < 120) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
    end
    burst_left--;
  endtask

  function automatic void set_scalers(input field_t v);
    foreach (scal[k]) scal[k] = v;
  endfunction

  // Distinct steps per scaler, so a swapped lane shows up.
  function automatic void bump_scalers(input field_t step);
    foreach (scal[k]) scal[k] = scal[k] + step * field_t'(k + 1);
  endfunction

  function automatic void advance_scalers();
    foreach (scal[k]) begin
      case ($urandom_range(0, 19))
        0:       scal[k] = $urandom();   // jump anywhere, often through the wrap
        1:       ;                       // hold
        default: scal[k] = scal[k] + field_t'($urandom_range(0, 50000));
      endcase
    end
  endfunction

  task automatic paced_readout(input field_t start, input field_t stop);
    pace_sender();
    advance_scalers();
    send_readout(start, stop);
  endtask

  // One spill: a readout that mostly closes a spill, then readouts inside the spill.
  task automatic run_spill();
    field_t start;
    field_t stop;
    field_t gap;
    int     n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        stop = mirror_stop + 1'b1;
        start = ($urandom_range(0, 3) == 0) ? field_t'($urandom())
                                             : mirror_start + field_t'($urandom_range(0, 20));
      end
      6, 7: begin
        stop = $urandom();
        start = $urandom();
      end
      default: begin
        if (mirror_start != '0) begin
          stop = mirror_stop;
          start = $urandom_range(0, mirror_start - 1'b1);
        end else begin
          stop = mirror_stop + 1'b1;
          start = '0;
        end
      end
    endcase
    paced_readout(start, stop);
    n = $urandom_range(0, 12);
    repeat (n) begin
      gap = '1 - mirror_start;
      if (gap == '0 || $urandom_range(0, 9) == 0) begin
        start = mirror_start;   // unchanged counters: the readout is dropped
      end else if ($urandom_range(0, 9) == 0) begin
        start = mirror_start + field_t'($urandom_range(1, gap));
      end else begin
        start = mirror_start + field_t'($urandom_range(1, (gap < 1000) ? gap : 1000));
      end
      paced_readout(start, mirror_stop);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      pace_sender();
      foreach (scal[k]) scal[k] = $urandom();
      send_readout($urandom(), $urandom());
    end
  endtask

  initial begin
    logic paused_once;
    paused_once = 1'b0;
    set_scalers('0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases, back to back.
    set_scalers('1);
    send_readout(32'hFFFF_FFF0, '1);   // first readout: latch only
    send_readout(32'hFFFF_FFF0, '1);   // nothing changed
    bump_scalers(32'd3);               // scalers wrap through zero
    send_readout(32'hFFFF_FFF5, '1);   // start grows: accumulate
    bump_scalers(32'h8000_0000);
    send_readout('1, '1);              // start at its top
    bump_scalers(32'd7);
    send_readout(32'hFFFF_FFF0, '1);   // back at the latched start: dropped
    bump_scalers(32'd1);
    send_readout(32'hFFFF_FFF1, '1);   // still above the latched start: accumulate
    send_readout('0, '1);              // start falls: close
    send_readout('0, '0);              // stop changes: close
    send_readout('0, '0);              // dropped
    set_scalers('0);
    send_readout(32'd1, '0);           // accumulate as the readings drop to zero
    bump_scalers(32'h5555_5555);
    send_readout(32'd2, '0);
    bump_scalers(32'hAAAA_AAAA);
    send_readout(32'd2, 32'd1);        // start held, stop grows: close
    send_readout(32'd3, '0);           // stop falls: close with zero deltas
    bump_scalers(32'd1);
    send_readout('1, '1);              // both counters jump to the top: close
    send_readout(32'd5, '1);           // start falls from the top: close
    bump_scalers(32'h7FFF_FFFF);
    send_readout(32'd6, '1);
    send_readout(32'd6, '1);           // accumulate with zero deltas
    send_readout(32'd5, '1);           // dropped
    bump_scalers(32'd1);
    send_readout(32'd5, 32'hFFFF_FFFE);
    wait_for_results();

    // Random spills, with some noise readouts in between.
    while (readouts_sent < ReadoutTarget) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        run_spill();
      end
      if (!paused_once && readouts_sent >= ReadoutTarget / 2) begin
        wait_for_results();
        paused_once = 1'b1;
      end
    end
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d readouts: %0d spill results checked, %0d readouts added to totals",
             readouts_sent, closed_count, grown_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ssra_pkg.sv
design/ssra_tracker.sv
design/spill_scaler_rate_accumulator.sv
verif/spill_total_checker.sv
verif/tb_spill_scaler_rate_accumulator.sv
